### rtl/core/lts_pkg.sv
// Shared types, constants and reset values for the lottery task scheduler.
`default_nettype none
package lts_pkg;

  // Sizing
  localparam int MAX_TASKS   = 16;
  localparam int TASK_W      = 4;
  localparam int IDX_W       = $clog2(MAX_TASKS);
  localparam int LEN_W       = $clog2(MAX_TASKS + 1);
  localparam int TICKET_W    = 8;
  localparam int QUANTUM_W   = 8;
  localparam int RND_W       = 16;
  localparam int RANDOM_BITS = 16;
  localparam int BIT_CNT_W   = $clog2(RANDOM_BITS);
  localparam int TOTAL_W     = $clog2(MAX_TASKS * ((1 << TICKET_W) - 1) + 1);
  localparam int OP_W        = 3;
  localparam int PRIO_W      = 2;
  localparam int NUM_PRIO    = 4;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_W       = 8;
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

  // Register reset values
  localparam logic [TICKET_W-1:0] TICKETS_RESET [NUM_PRIO] = '{8'd50, 8'd25, 8'd10, 8'd5};
  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 8'd3;

  // Input opcodes
  typedef enum logic [OP_W-1:0] {
    OP_NEW     = 3'd0,
    OP_ENQUEUE = 3'd1,
    OP_PICK    = 3'd2,
    OP_TICK    = 3'd3,
    OP_STEAL   = 3'd4
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICKETS0 = 3'd0,
    CFG_TICKETS1 = 3'd1,
    CFG_TICKETS2 = 3'd2,
    CFG_TICKETS3 = 3'd3,
    CFG_QUANTUM  = 3'd4
  } cfg_idx_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_EMPTY   = 2'd2
  } status_t;

  // Classified command kinds handed from front to back
  typedef enum logic [2:0] {
    CMD_NEW,
    CMD_ENQUEUE,
    CMD_PICK,
    CMD_TICK,
    CMD_STEAL,
    CMD_IGNORE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [TASK_W-1:0]       tid;
    logic [PRIO_W-1:0]       prio;
    logic [RANDOM_BITS-1:0]  rnd;
  } cmd_t;

  typedef struct packed {
    logic              task_valid;
    logic [TASK_W-1:0] chosen_task;
    logic              resched_req;
    status_t           status;
  } res_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SUM,
    BK_MOD,
    BK_WALK,
    BK_DROP
  } back_state_t;

endpackage
`default_nettype wire

### rtl/core/lottery_task_scheduler.sv
// Lottery task scheduler: front end, command queue and back end.
// New, enqueue, tick and steal beats pass through the command queue to the result register,
// and the back end retires one of them per cycle while the result register drains.
// A pick runs through the one-entry-per-cycle ticket sum and walk and the bit-serial
// modulo unit, in the order sum, modulo, walk, and then drops the winner.
// Reset (synchronous) empties the run queue and command queue and restores the config
// registers; per-task ticket and tick tables hold no value until a new-task beat.
`default_nettype none
module lottery_task_scheduler (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [lts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lts_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [lts_pkg::OP_W-1:0]        op,
  input  wire logic [lts_pkg::TASK_W-1:0]      task_id,
  input  wire logic [lts_pkg::PRIO_W-1:0]      prio,
  input  wire logic                            is_idle,
  input  wire logic [lts_pkg::RND_W-1:0]       random_word,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 task_valid,
  output logic [lts_pkg::TASK_W-1:0]           chosen_task,
  output logic                                 resched_req,
  output logic [lts_pkg::STATUS_W-1:0]         status
);

  logic          push_valid;
  logic          push_ready;
  lts_pkg::cmd_t push_cmd;
  logic          pop_valid;
  logic          pop_ready;
  lts_pkg::cmd_t pop_cmd;
  lts_pkg::res_t res;

  lts_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .task_id     (task_id),
    .prio        (prio),
    .is_idle     (is_idle),
    .random_word (random_word),
    .push_valid  (push_valid),
    .push_ready  (push_ready),
    .push_cmd    (push_cmd)
  );

  lts_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  lts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (pop_valid),
    .cmd_ready (pop_ready),
    .cmd       (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  // Result fields
  assign task_valid  = res.task_valid;
  assign chosen_task = res.chosen_task;
  assign resched_req = res.resched_req;
  assign status      = res.status;

endmodule
`default_nettype wire

### rtl/core/lts_front.sv
// Front end: takes input beats and classifies them into back-end commands.
`default_nettype none
module lts_front (
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [lts_pkg::OP_W-1:0]      op,
  input  wire logic [lts_pkg::TASK_W-1:0]    task_id,
  input  wire logic [lts_pkg::PRIO_W-1:0]    prio,
  input  wire logic                          is_idle,
  input  wire logic [lts_pkg::RND_W-1:0]     random_word,
  output logic                               push_valid,
  input  wire logic                          push_ready,
  output lts_pkg::cmd_t                      push_cmd
);

  logic tid_ok;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  // Task number must name a real slot
  assign tid_ok = ({1'b0, task_id} < lts_pkg::LEN_W'(lts_pkg::MAX_TASKS));

  // Classify the beat; idle-task enqueue and tick requests, out-of-range task numbers and unknown opcodes become no-ops
  always_comb begin
    push_cmd.tid  = task_id;
    push_cmd.prio = prio;
    push_cmd.rnd  = random_word[lts_pkg::RANDOM_BITS-1:0];
    case (lts_pkg::op_t'(op))
      lts_pkg::OP_NEW: begin
        push_cmd.kind = tid_ok ? lts_pkg::CMD_NEW : lts_pkg::CMD_IGNORE;
      end
      lts_pkg::OP_ENQUEUE: begin
        push_cmd.kind = (tid_ok && !is_idle) ? lts_pkg::CMD_ENQUEUE : lts_pkg::CMD_IGNORE;
      end
      lts_pkg::OP_PICK: begin
        push_cmd.kind = lts_pkg::CMD_PICK;
      end
      lts_pkg::OP_TICK: begin
        push_cmd.kind = (tid_ok && !is_idle) ? lts_pkg::CMD_TICK : lts_pkg::CMD_IGNORE;
      end
      lts_pkg::OP_STEAL: begin
        push_cmd.kind = lts_pkg::CMD_STEAL;
      end
      default: begin
        push_cmd.kind = lts_pkg::CMD_IGNORE;
      end
    endcase
  end

endmodule
`default_nettype wire

### rtl/core/lts_cmd_fifo.sv
// Short command queue between the scheduler front end and back end.
`default_nettype none
module lts_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  output logic               push_ready,
  input  wire lts_pkg::cmd_t push_cmd,
  output logic               pop_valid,
  input  wire logic          pop_ready,
  output lts_pkg::cmd_t      pop_cmd
);

  lts_pkg::cmd_t                    entries [lts_pkg::FIFO_DEPTH];
  logic [lts_pkg::FIFO_PTR_W-1:0]   wr_ptr;
  logic [lts_pkg::FIFO_PTR_W-1:0]   rd_ptr;
  logic [lts_pkg::FIFO_CNT_W-1:0]   count;
  logic                             do_push;
  logic                             do_pop;

  assign push_ready = (count != lts_pkg::FIFO_CNT_W'(lts_pkg::FIFO_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_cmd;
  end

endmodule
`default_nettype wire

### rtl/core/lts_back.sv
// Back end: run queue, per-task tables, lottery draw sequencer and result register.
`default_nettype none
module lts_back (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [lts_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lts_pkg::CFG_W-1:0]       cfg_data,
  input  wire logic                            cmd_valid,
  output logic                                 cmd_ready,
  input  wire lts_pkg::cmd_t                   cmd,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output lts_pkg::res_t                        res
);

  // Configuration
  logic [lts_pkg::TICKET_W-1:0]  tickets [lts_pkg::NUM_PRIO];
  logic [lts_pkg::QUANTUM_W-1:0] quantum;

  // Run queue and per-task tables
  logic [lts_pkg::TASK_W-1:0]    q [lts_pkg::MAX_TASKS];
  logic [lts_pkg::MAX_TASKS-1:0] in_q;
  logic [lts_pkg::LEN_W-1:0]     len;
  logic [lts_pkg::TICKET_W-1:0]  tc [lts_pkg::MAX_TASKS];
  logic [lts_pkg::QUANTUM_W-1:0] tl [lts_pkg::MAX_TASKS];

  // Draw sequencer
  lts_pkg::back_state_t            state, state_next;
  logic [lts_pkg::IDX_W-1:0]       k;
  logic [lts_pkg::TOTAL_W-1:0]     total;
  logic [lts_pkg::TOTAL_W-1:0]     sum;
  logic [lts_pkg::TOTAL_W-1:0]     rem;
  logic [lts_pkg::RANDOM_BITS-1:0] rnd_sh;
  logic [lts_pkg::BIT_CNT_W-1:0]   bit_cnt;

  // Datapath taps
  logic [lts_pkg::LEN_W-1:0]     len_m1;
  logic [lts_pkg::IDX_W-1:0]     q_addr;
  logic [lts_pkg::TASK_W-1:0]    q_rd;
  logic [lts_pkg::TICKET_W-1:0]  tc_rd;
  logic [lts_pkg::QUANTUM_W-1:0] tl_rd;
  logic [lts_pkg::QUANTUM_W-1:0] tick_new;
  logic [lts_pkg::TOTAL_W-1:0]   total_add;
  logic [lts_pkg::TOTAL_W-1:0]   sum_add;
  logic [lts_pkg::TOTAL_W:0]     rem_sh;
  logic [lts_pkg::TOTAL_W:0]     rem_sub;
  logic [lts_pkg::TOTAL_W-1:0]   rem_new;
  logic                          last_k;
  logic                          hit;
  logic                          enq_ok;
  logic                          out_free;
  logic                          res_load;
  lts_pkg::res_t                 res_next;

  assign len_m1    = len - 1'b1;
  assign q_addr    = (state == lts_pkg::BK_IDLE) ? len_m1[lts_pkg::IDX_W-1:0] : k;
  assign q_rd      = q[q_addr];
  assign tc_rd     = tc[q_rd];
  assign tl_rd     = tl[cmd.tid];
  assign tick_new  = (tl_rd != '0) ? tl_rd - 1'b1 : '0;
  assign total_add = total + lts_pkg::TOTAL_W'(tc_rd);
  assign sum_add   = sum + lts_pkg::TOTAL_W'(tc_rd);
  assign last_k    = (lts_pkg::LEN_W'(k) == len_m1);
  assign hit       = (rem < sum_add);
  assign enq_ok    = !in_q[cmd.tid] && (len < lts_pkg::LEN_W'(lts_pkg::MAX_TASKS));
  assign out_free  = !out_valid || out_ready;
  assign cmd_ready = (state == lts_pkg::BK_IDLE) && out_free;

  // One restoring-division step per cycle: draw = random mod total
  assign rem_sh  = {rem, rnd_sh[lts_pkg::RANDOM_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, total};
  assign rem_new = (rem_sh >= {1'b0, total}) ? rem_sub[lts_pkg::TOTAL_W-1:0]
                                             : rem_sh[lts_pkg::TOTAL_W-1:0];

  // Next state and result
  always_comb begin
    state_next            = state;
    res_load              = 1'b0;
    res_next.task_valid   = 1'b0;
    res_next.chosen_task  = '0;
    res_next.resched_req  = 1'b0;
    res_next.status       = lts_pkg::ST_DONE;
    case (state)
      lts_pkg::BK_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          case (cmd.kind)
            lts_pkg::CMD_NEW: begin
              res_load = 1'b1;
            end
            lts_pkg::CMD_ENQUEUE: begin
              res_load        = 1'b1;
              res_next.status = enq_ok ? lts_pkg::ST_DONE : lts_pkg::ST_IGNORED;
            end
            lts_pkg::CMD_PICK: begin
              if (len == '0) begin
                res_load        = 1'b1;
                res_next.status = lts_pkg::ST_EMPTY;
              end else begin
                state_next = lts_pkg::BK_SUM;
              end
            end
            lts_pkg::CMD_TICK: begin
              res_load             = 1'b1;
              res_next.resched_req = (tick_new == '0);
            end
            lts_pkg::CMD_STEAL: begin
              res_load = 1'b1;
              if (len == '0) begin
                res_next.status = lts_pkg::ST_EMPTY;
              end else begin
                res_next.task_valid  = 1'b1;
                res_next.chosen_task = q_rd;
              end
            end
            default: begin
              res_load        = 1'b1;
              res_next.status = lts_pkg::ST_IGNORED;
            end
          endcase
        end
      end
      lts_pkg::BK_SUM: begin
        if (last_k) begin
          if (total_add == '0) begin
            res_load        = 1'b1;
            res_next.status = lts_pkg::ST_EMPTY;
            state_next      = lts_pkg::BK_IDLE;
          end else begin
            state_next = lts_pkg::BK_MOD;
          end
        end
      end
      lts_pkg::BK_MOD: begin
        if (bit_cnt == lts_pkg::BIT_CNT_W'(lts_pkg::RANDOM_BITS - 1)) begin
          state_next = lts_pkg::BK_WALK;
        end
      end
      lts_pkg::BK_WALK: begin
        if (hit || last_k) state_next = lts_pkg::BK_DROP;
      end
      lts_pkg::BK_DROP: begin
        res_load             = 1'b1;
        res_next.task_valid  = 1'b1;
        res_next.chosen_task = q_rd;
        state_next           = lts_pkg::BK_IDLE;
      end
      default: begin
        state_next = lts_pkg::BK_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= lts_pkg::BK_IDLE;
    else     state <= state_next;
  end

  // Control state: config, queue length, membership, result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      tickets   <= lts_pkg::TICKETS_RESET;
      quantum   <= lts_pkg::QUANTUM_RESET;
      len       <= '0;
      in_q      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (lts_pkg::cfg_idx_t'(cfg_index))
          lts_pkg::CFG_TICKETS0: tickets[0] <= cfg_data;
          lts_pkg::CFG_TICKETS1: tickets[1] <= cfg_data;
          lts_pkg::CFG_TICKETS2: tickets[2] <= cfg_data;
          lts_pkg::CFG_TICKETS3: tickets[3] <= cfg_data;
          lts_pkg::CFG_QUANTUM:  quantum    <= cfg_data;
          default: ;
        endcase
      end
      if (res_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      if (state == lts_pkg::BK_IDLE && cmd_valid && cmd_ready) begin
        if (cmd.kind == lts_pkg::CMD_ENQUEUE && enq_ok) begin
          len            <= len + 1'b1;
          in_q[cmd.tid]  <= 1'b1;
        end else if (cmd.kind == lts_pkg::CMD_STEAL && len != '0) begin
          len         <= len_m1;
          in_q[q_rd]  <= 1'b0;
        end
      end else if (state == lts_pkg::BK_DROP) begin
        len        <= len_m1;
        in_q[q_rd] <= 1'b0;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (res_load) res <= res_next;
  end

  // Queue entries, task tables and sequencer datapath
  always_ff @(posedge clk) begin
    case (state)
      lts_pkg::BK_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          case (cmd.kind)
            lts_pkg::CMD_NEW: begin
              tc[cmd.tid] <= tickets[cmd.prio];
              tl[cmd.tid] <= quantum;
            end
            lts_pkg::CMD_ENQUEUE: begin
              if (enq_ok) q[len[lts_pkg::IDX_W-1:0]] <= cmd.tid;
            end
            lts_pkg::CMD_TICK: begin
              tl[cmd.tid] <= tick_new;
            end
            lts_pkg::CMD_PICK: begin
              k      <= '0;
              total  <= '0;
              rnd_sh <= cmd.rnd;
            end
            default: ;
          endcase
        end
      end
      lts_pkg::BK_SUM: begin
        total <= total_add;
        if (last_k) begin
          rem     <= '0;
          bit_cnt <= '0;
        end else begin
          k <= k + 1'b1;
        end
      end
      lts_pkg::BK_MOD: begin
        rem     <= rem_new;
        rnd_sh  <= rnd_sh << 1;
        bit_cnt <= bit_cnt + 1'b1;
        k       <= '0;
        sum     <= '0;
      end
      lts_pkg::BK_WALK: begin
        sum <= sum_add;
        if (!(hit || last_k)) k <= k + 1'b1;
      end
      lts_pkg::BK_DROP: begin
        // close the gap left by the winner
        for (int j = 0; j < lts_pkg::MAX_TASKS - 1; j++) begin
          if (lts_pkg::IDX_W'(j) >= k) q[j] <= q[j+1];
        end
        tc[q_rd] <= (tc_rd != '0) ? tc_rd - 1'b1 : '0;
        tl[q_rd] <= quantum;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### dv/lottery_task_scheduler_test.sv
// Self-checking testbench for the lottery task scheduler: directed table, then random phases.
`default_nettype none
module lottery_task_scheduler_test;
  import lts_pkg::*;

  localparam int NUM_ROWS   = 24;
  localparam int ZERO_ROW   = 19;   // row before which prio-3 tickets drop to zero
  localparam int NUM_PHASES = 13;
  localparam int PHASE_LEN  = 100;
  localparam int QUIET_MAX  = 2000;
  localparam int TAIL_WAIT  = 60;
  localparam logic [OP_W-1:0] OP_BAD_LO = 3'd5;
  localparam logic [OP_W-1:0] OP_BAD_HI = 3'd7;

  // Typed results for rows whose outcome is plain
  localparam res_t R_DONE    = '{1'b0, 4'd0, 1'b0, ST_DONE};
  localparam res_t R_IGN     = '{1'b0, 4'd0, 1'b0, ST_IGNORED};
  localparam res_t R_EMPTY   = '{1'b0, 4'd0, 1'b0, ST_EMPTY};
  localparam res_t R_RESCHED = '{1'b0, 4'd0, 1'b1, ST_DONE};
  localparam res_t R_GOT15   = '{1'b1, 4'd15, 1'b0, ST_DONE};

  typedef struct packed {
    logic [OP_W-1:0]   code;
    logic [TASK_W-1:0] tid;
    logic [PRIO_W-1:0] pr;
    logic              idle;
    logic [RND_W-1:0]  rnd;
    logic              fixed;
    res_t              want;
  } row_t;

  // Directed rows; fixed=0 rows go through the predictor
  localparam row_t PLAN [NUM_ROWS] = '{
    '{OP_PICK,    4'd0,  2'd0, 1'b0, 16'h0000, 1'b1, R_EMPTY},
    '{OP_STEAL,   4'd0,  2'd0, 1'b0, 16'h0000, 1'b1, R_EMPTY},
    '{OP_BAD_LO,  4'd9,  2'd2, 1'b1, 16'hAAAA, 1'b1, R_IGN},
    '{OP_BAD_HI,  4'd6,  2'd1, 1'b0, 16'h5555, 1'b1, R_IGN},
    '{OP_ENQUEUE, 4'd15, 2'd0, 1'b1, 16'h0000, 1'b1, R_IGN},
    '{OP_TICK,    4'd0,  2'd0, 1'b1, 16'h0000, 1'b1, R_IGN},
    '{OP_NEW,     4'd0,  2'd0, 1'b0, 16'h0000, 1'b1, R_DONE},
    '{OP_NEW,     4'd15, 2'd3, 1'b1, 16'hFFFF, 1'b1, R_DONE},
    '{OP_TICK,    4'd15, 2'd0, 1'b0, 16'h0000, 1'b1, R_DONE},
    '{OP_TICK,    4'd15, 2'd0, 1'b0, 16'h0000, 1'b1, R_DONE},
    '{OP_TICK,    4'd15, 2'd0, 1'b0, 16'h0000, 1'b1, R_RESCHED},
    '{OP_TICK,    4'd15, 2'd0, 1'b0, 16'h0000, 1'b1, R_RESCHED},
    '{OP_ENQUEUE, 4'd0,  2'd0, 1'b0, 16'h0000, 1'b1, R_DONE},
    '{OP_ENQUEUE, 4'd0,  2'd0, 1'b0, 16'h0000, 1'b1, R_IGN},
    '{OP_ENQUEUE, 4'd15, 2'd0, 1'b0, 16'h0000, 1'b1, R_DONE},
    '{OP_PICK,    4'd0,  2'd0, 1'b0, 16'hFFFF, 1'b0, R_DONE},
    '{OP_ENQUEUE, 4'd0,  2'd0, 1'b0, 16'h0000, 1'b0, R_DONE},
    '{OP_STEAL,   4'd0,  2'd0, 1'b0, 16'h0000, 1'b0, R_DONE},
    '{OP_PICK,    4'd0,  2'd0, 1'b0, 16'h0000, 1'b0, R_DONE},
    '{OP_NEW,     4'd15, 2'd3, 1'b0, 16'h0000, 1'b1, R_DONE},
    '{OP_ENQUEUE, 4'd15, 2'd0, 1'b0, 16'h0000, 1'b1, R_DONE},
    '{OP_PICK,    4'd0,  2'd0, 1'b0, 16'h1234, 1'b1, R_EMPTY},
    '{OP_STEAL,   4'd0,  2'd0, 1'b0, 16'h0000, 1'b1, R_GOT15},
    '{OP_NEW,     4'd1,  2'd1, 1'b0, 16'h0000, 1'b1, R_DONE}
  };

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      op = '0;
  logic [TASK_W-1:0]    task_id = '0;
  logic [PRIO_W-1:0]    prio = '0;
  logic                 is_idle = 1'b0;
  logic [RND_W-1:0]     random_word = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 task_valid;
  logic [TASK_W-1:0]    chosen_task;
  logic                 resched_req;
  logic [STATUS_W-1:0]  status;

  // Side info travelling with each input beat
  logic drv_fixed = 1'b0;
  res_t drv_want = R_DONE;

  res_t awaited_results [$];
  int   mismatches = 0;
  int   quiet = 0;
  bit   calm = 1'b0;
  bit   known [MAX_TASKS];

  // Scheduler state mirrored by the predictor
  logic [TICKET_W-1:0]  prio_tickets [NUM_PRIO] = '{8'd50, 8'd25, 8'd10, 8'd5};
  logic [QUANTUM_W-1:0] slice_len = 8'd3;
  logic [TASK_W-1:0]    run_queue [MAX_TASKS];
  int                   run_len = 0;
  bit                   on_queue [MAX_TASKS];
  logic [TICKET_W-1:0]  tickets [MAX_TASKS];
  logic [QUANTUM_W-1:0] slice_left [MAX_TASKS];

  lottery_task_scheduler u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .task_id      (task_id),
    .prio         (prio),
    .is_idle      (is_idle),
    .random_word  (random_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .task_valid   (task_valid),
    .chosen_task  (chosen_task),
    .resched_req  (resched_req),
    .status       (status)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Take a task out of the run queue and close the gap
  function automatic logic [TASK_W-1:0] unlink(input int pos);
    logic [TASK_W-1:0] id;
    id = run_queue[pos];
    for (int k = pos; k + 1 < run_len; k++) run_queue[k] = run_queue[k + 1];
    run_len--;
    on_queue[id] = 1'b0;
    return id;
  endfunction

  // Predicted outcome of one command; updates the mirrored state
  function automatic res_t lottery_step(input logic [OP_W-1:0] code,
                                        input logic [TASK_W-1:0] tid,
                                        input logic [PRIO_W-1:0] pr,
                                        input logic idle,
                                        input logic [RND_W-1:0] rnd);
    res_t r;
    int   total, acc, draw, pos;
    bit   found;
    r = R_IGN;
    case (op_t'(code))
      OP_NEW: begin
        tickets[tid] = prio_tickets[pr];
        slice_left[tid] = slice_len;
        r.status = ST_DONE;
      end
      OP_ENQUEUE: begin
        if (!on_queue[tid] && !idle && run_len < MAX_TASKS) begin
          run_queue[run_len] = tid;
          run_len++;
          on_queue[tid] = 1'b1;
          r.status = ST_DONE;
        end
      end
      OP_PICK: begin
        total = 0;
        for (int k = 0; k < run_len; k++) total += tickets[run_queue[k]];
        if (total == 0) begin
          r.status = ST_EMPTY;
        end else begin
          draw = int'(rnd) % total;
          acc = 0;
          pos = run_len - 1;
          found = 1'b0;
          for (int k = 0; k < run_len; k++) begin
            acc += tickets[run_queue[k]];
            if (!found && draw < acc) begin
              pos = k;
              found = 1'b1;
            end
          end
          r.chosen_task = unlink(pos);
          if (tickets[r.chosen_task] > 0) tickets[r.chosen_task]--;
          slice_left[r.chosen_task] = slice_len;
          r.task_valid = 1'b1;
          r.status = ST_DONE;
        end
      end
      OP_TICK: begin
        if (!idle) begin
          if (slice_left[tid] > 0) slice_left[tid]--;
          if (slice_left[tid] == 0) r.resched_req = 1'b1;
          r.status = ST_DONE;
        end
      end
      OP_STEAL: begin
        if (run_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.chosen_task = unlink(run_len - 1);
          r.task_valid = 1'b1;
          r.status = ST_DONE;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Scoreboard: config, input beats and output beats in one place per edge
  always @(posedge clk) begin : scoreboard
    res_t want;
    if (!rst) begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_TICKETS0, CFG_TICKETS1, CFG_TICKETS2, CFG_TICKETS3:
            prio_tickets[cfg_index[1:0]] = cfg_data;
          CFG_QUANTUM: slice_len = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = lottery_step(op, task_id, prio, is_idle, random_word);
        if (drv_fixed) want = drv_want;
        awaited_results.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("task_valid", want.task_valid, task_valid);
          check_field("chosen_task", want.chosen_task, chosen_task);
          check_field("resched_req", want.resched_req, resched_req);
          check_field("status", want.status, status);
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Result side: random stall before each beat, none while calm
  initial begin : sink
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Drive one input beat after a random gap (none while calm); returns at the accepting edge
  task automatic send_beat(input logic [OP_W-1:0] code, input logic [TASK_W-1:0] tid,
                           input logic [PRIO_W-1:0] pr, input logic idle,
                           input logic [RND_W-1:0] rnd, input logic fixed, input res_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= code;
    task_id     <= tid;
    prio        <= pr;
    is_idle     <= idle;
    random_word <= rnd;
    drv_fixed   <= fixed;
    drv_want    <= want;
    if (code == OP_NEW) known[tid] = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender until every expected result is back
  task automatic drain;
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [OP_W-1:0]   code;
    logic [TASK_W-1:0] tid;
    logic [PRIO_W-1:0] pr;
    logic              idle;
    logic [RND_W-1:0]  rnd;
    logic [CFG_W-1:0]  val;
    int                sel;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < NUM_ROWS; i++) begin
      if (i == ZERO_ROW) begin
        // zero tickets for priority 3 so a queued task holds none
        drain();
        set_reg(CFG_TICKETS3, 8'd0);
        cfg_we <= 1'b0;
      end
      send_beat(PLAN[i].code, PLAN[i].tid, PLAN[i].pr, PLAN[i].idle, PLAN[i].rnd,
                PLAN[i].fixed, PLAN[i].want);
    end

    // Random phases, each under its own register setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      for (int r = 0; r < NUM_PRIO + 1; r++) begin
        case (ph)
          0: val = (r == CFG_QUANTUM) ? 8'd1 : 8'd0;
          1: val = 8'hFF;
          default: begin
            sel = $urandom_range(0, 3);
            val = (sel == 0) ? 8'd0 : (sel == 1) ? 8'hFF : 8'($urandom_range(1, 254));
          end
        endcase
        if (r == CFG_QUANTUM && val == 0) val = 8'd1;
        set_reg(cfg_idx_t'(r), val);
      end
      cfg_we <= 1'b0;

      for (int n = 0; n < PHASE_LEN; n++) begin
        if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
        tid  = $urandom_range(0, MAX_TASKS - 1);
        pr   = $urandom_range(0, NUM_PRIO - 1);
        idle = ($urandom_range(0, 9) == 0);
        sel  = $urandom_range(0, 9);
        rnd  = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
        sel  = $urandom_range(0, 99);
        if (sel < 15)      code = OP_NEW;
        else if (sel < 45) code = OP_ENQUEUE;
        else if (sel < 65) code = OP_PICK;
        else if (sel < 85) code = OP_TICK;
        else if (sel < 96) code = OP_STEAL;
        else               code = 3'($urandom_range(OP_BAD_HI, OP_BAD_LO));
        // a task must get its tickets before it can be queued or charged
        if ((code == OP_ENQUEUE || code == OP_TICK) && !idle && !known[tid]) code = OP_NEW;
        send_beat(code, tid, pr, idle, rnd, 1'b0, R_DONE);
      end
    end

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
rtl/core/lts_pkg.sv
rtl/core/lts_front.sv
rtl/core/lts_cmd_fifo.sv
rtl/core/lts_back.sv
rtl/core/lottery_task_scheduler.sv
dv/lottery_task_scheduler_test.sv
